// ===== hdl/lpr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the line pixel rasterizer
// Item layouts, command records passed from front to back, config registers.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_BITS = 10;
  localparam int DIM_BITS   = 11;
  localparam int ADDR_BITS  = 32;
  localparam int COLOR_BITS = 32;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int PROD_BITS  = COORD_BITS + DIM_BITS;
  localparam int IDX_BITS   = PROD_BITS + 1;

  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = QPTR_BITS + 1;

  localparam int CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_BASE    = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_IDLE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_HORIZ = 2'd0,
    MODE_VERT  = 2'd1,
    MODE_DIAG  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_ADVANCE = 2'd0,
    CMD_START   = 2'd1,
    CMD_REJECT  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] stop_x;
    logic [COORD_BITS-1:0] stop_y;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    status_e               status;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last;
    logic                  write_valid;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] frame_base;
    logic [DIM_BITS-1:0]  screen_width;
    logic [DIM_BITS-1:0]  screen_height;
  } cfg_t;

  typedef struct packed {
    cmd_e                         kind;
    mode_e                        mode;
    logic [COORD_BITS-1:0]        cur_col;
    logic [COORD_BITS-1:0]        cur_row;
    logic [COORD_BITS-1:0]        end_col;
    logic [COORD_BITS-1:0]        end_row;
    logic [DELTA_BITS-1:0]        delta_col;
    logic [DELTA_BITS-1:0]        delta_row;
    logic                         dir_col;
    logic                         dir_row;
    logic signed [ERR_BITS-1:0]   err;
    logic [COLOR_BITS-1:0]        color;
  } cmd_t;

endpackage

// ===== hdl/line_pixel_rasterizer.sv =====
// ----------------------------------------------------------------------------
// line_pixel_rasterizer: Bresenham line to frame-buffer pixel writes
// Path: item acceptance, then the queue, then the walker output register.
// Throughput: one item per cycle while the output is not stalled; the
// walker's single error update and the row*width address multiply are
// combinational.
// Reset: no line active, queue and output empty, config at its reset values.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lpr_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lpr_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_we_i,
  input  logic [lpr_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lpr_pkg::ADDR_BITS-1:0]       cfg_data_i
);
  import lpr_pkg::*;

  cfg_t cfg_q;
  logic q_full, push, q_valid, pop;
  cmd_t front_cmd, q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base    <= 32'hC000_0000;
      cfg_q.screen_width  <= DIM_BITS'(800);
      cfg_q.screen_height <= DIM_BITS'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_BASE:    cfg_q.frame_base    <= cfg_data_i;
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i[DIM_BITS-1:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  lpr_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  lpr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  lpr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/lpr_front.sv =====
// ----------------------------------------------------------------------------
// lpr_front: input acceptance and classification
// Range-checks start items and precomputes walk mode, deltas and error term.
// ----------------------------------------------------------------------------
module lpr_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lpr_pkg::in_item_t in_item_i,
  input  lpr_pkg::cfg_t    cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output lpr_pkg::cmd_t    cmd_o
);
  import lpr_pkg::*;

  logic [COORD_BITS-1:0] x1, y1, x2, y2, dc, dr;
  logic                  x_lt, y_lt, reject;

  assign x1 = in_item_i.start_x;
  assign y1 = in_item_i.start_y;
  assign x2 = in_item_i.stop_x;
  assign y2 = in_item_i.stop_y;

  assign x_lt = x1 < x2;
  assign y_lt = y1 < y2;
  assign dc   = x_lt ? (x2 - x1) : (x1 - x2);
  assign dr   = y_lt ? (y2 - y1) : (y1 - y2);

  assign reject = (CMP_BITS'(x1) >= CMP_BITS'(cfg_i.screen_width))  ||
                  (CMP_BITS'(x2) >= CMP_BITS'(cfg_i.screen_width))  ||
                  (CMP_BITS'(y1) >= CMP_BITS'(cfg_i.screen_height)) ||
                  (CMP_BITS'(y2) >= CMP_BITS'(cfg_i.screen_height));

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = CMD_ADVANCE;
    cmd_o.mode      = MODE_HORIZ;
    cmd_o.delta_col = DELTA_BITS'(dc);
    cmd_o.delta_row = DELTA_BITS'(dr);
    cmd_o.dir_col   = !x_lt;
    cmd_o.dir_row   = !y_lt;
    cmd_o.err       = $signed(ERR_BITS'(dc)) - $signed(ERR_BITS'(dr));
    cmd_o.color     = in_item_i.line_color;
    cmd_o.cur_col   = x1;
    cmd_o.cur_row   = y1;
    cmd_o.end_col   = x2;
    cmd_o.end_row   = y2;
    if (!in_item_i.req_type) begin
      if (reject) begin
        cmd_o.kind = CMD_REJECT;
      end else begin
        cmd_o.kind = CMD_START;
        if (y1 == y2) begin
          cmd_o.mode    = MODE_HORIZ;
          cmd_o.cur_col = x_lt ? x1 : x2;
          cmd_o.end_col = x_lt ? x2 : x1;
          cmd_o.end_row = y1;
        end else if (x1 == x2) begin
          cmd_o.mode    = MODE_VERT;
          cmd_o.cur_row = y_lt ? y1 : y2;
          cmd_o.end_row = y_lt ? y2 : y1;
          cmd_o.end_col = x1;
        end else begin
          cmd_o.mode = MODE_DIAG;
        end
      end
    end
  end

endmodule

// ===== hdl/lpr_queue.sv =====
// ----------------------------------------------------------------------------
// lpr_queue: short command queue between front and back
// Two entries; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module lpr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lpr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output lpr_pkg::cmd_t cmd_o
);
  import lpr_pkg::*;

  cmd_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o  = cnt_q == QCNT_BITS'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== hdl/lpr_back.sv =====
// ----------------------------------------------------------------------------
// lpr_back: line walker and output register
// Holds the active line, runs the Bresenham step and the pixel address.
// ----------------------------------------------------------------------------
module lpr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lpr_pkg::cfg_t      cfg_i,
  input  logic               cmd_valid_i,
  input  lpr_pkg::cmd_t      cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpr_pkg::out_item_t out_item_o
);
  import lpr_pkg::*;

  logic                       active_q, active_d;
  mode_e                      mode_q, mode_d;
  logic [COORD_BITS-1:0]      cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [COORD_BITS-1:0]      end_col_q, end_col_d, end_row_q, end_row_d;
  logic [DELTA_BITS-1:0]      dcol_q, dcol_d, drow_q, drow_d;
  logic                       dir_col_q, dir_col_d, dir_row_q, dir_row_d;
  logic signed [ERR_BITS-1:0] err_q, err_d;
  logic [COLOR_BITS-1:0]      color_q, color_d;
  logic                       out_valid_q, out_valid_d;
  out_item_t                  out_q, out_d;

  logic [PROD_BITS-1:0]       prod;
  logic [IDX_BITS-1:0]        pix_idx;
  logic [ADDR_BITS-1:0]       addr;
  logic signed [ERR_BITS:0]   e2, dc_s, dr_s, err_n;
  logic                       fin, step_col, step_row;

  assign pop_o       = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign prod    = PROD_BITS'(cur_row_q) * PROD_BITS'(cfg_i.screen_width);
  assign pix_idx = IDX_BITS'(prod) + IDX_BITS'(cur_col_q);
  assign addr    = cfg_i.frame_base + ADDR_BITS'({pix_idx, 2'b00});
  assign fin     = (cur_col_q == end_col_q) && (cur_row_q == end_row_q);

  assign e2       = {err_q, 1'b0};
  assign dc_s     = $signed((ERR_BITS+1)'(dcol_q));
  assign dr_s     = $signed((ERR_BITS+1)'(drow_q));
  assign step_col = e2 > -dr_s;
  assign step_row = e2 < dc_s;
  assign err_n    = (ERR_BITS+1)'(err_q) - (step_col ? dr_s : '0) + (step_row ? dc_s : '0);

  always_comb begin
    active_d  = active_q;
    mode_d    = mode_q;
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    end_col_d = end_col_q;
    end_row_d = end_row_q;
    dcol_d    = dcol_q;
    drow_d    = drow_q;
    dir_col_d = dir_col_q;
    dir_row_d = dir_row_q;
    err_d     = err_q;
    color_d   = color_q;
    out_d     = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.status = ST_OK;
      case (cmd_i.kind)
        CMD_REJECT: begin
          active_d     = 1'b0;
          out_d.status = ST_REJECT;
        end
        CMD_START: begin
          active_d  = 1'b1;
          mode_d    = cmd_i.mode;
          cur_col_d = cmd_i.cur_col;
          cur_row_d = cmd_i.cur_row;
          end_col_d = cmd_i.end_col;
          end_row_d = cmd_i.end_row;
          dcol_d    = cmd_i.delta_col;
          drow_d    = cmd_i.delta_row;
          dir_col_d = cmd_i.dir_col;
          dir_row_d = cmd_i.dir_row;
          err_d     = cmd_i.err;
          color_d   = cmd_i.color;
        end
        CMD_ADVANCE: begin
          if (!active_q) begin
            out_d.status = ST_IDLE;
          end else begin
            out_d.pixel_x     = cur_col_q;
            out_d.pixel_y     = cur_row_q;
            out_d.pixel_addr  = addr;
            out_d.pixel_color = color_q;
            out_d.last        = fin;
            out_d.write_valid = 1'b1;
            if (fin) begin
              active_d = 1'b0;
            end else begin
              case (mode_q)
                MODE_HORIZ: cur_col_d = cur_col_q + 1'b1;
                MODE_VERT:  cur_row_d = cur_row_q + 1'b1;
                default: begin
                  err_d = ERR_BITS'(err_n);
                  if (step_col) begin
                    cur_col_d = dir_col_q ? cur_col_q - 1'b1 : cur_col_q + 1'b1;
                  end
                  if (step_row) begin
                    cur_row_d = dir_row_q ? cur_row_q - 1'b1 : cur_row_q + 1'b1;
                  end
                end
              endcase
            end
          end
        end
        default: begin
          out_d.status = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    cur_col_q <= cur_col_d;
    cur_row_q <= cur_row_d;
    end_col_q <= end_col_d;
    end_row_q <= end_row_d;
    dcol_q    <= dcol_d;
    drow_q    <= drow_d;
    dir_col_q <= dir_col_d;
    dir_row_q <= dir_row_d;
    err_q     <= err_d;
    color_q   <= color_d;
    out_q     <= out_d;
  end

endmodule

// ===== hdl/lpr_checker.sv =====
// ----------------------------------------------------------------------------
// lpr_checker: port-level checks of the line pixel rasterizer
// Output hold under stall and consistency of result fields.
// ----------------------------------------------------------------------------
module lpr_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input lpr_pkg::out_item_t               out_item_o
);
  import lpr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_valid |-> out_item_o.status == ST_OK)
    else $error("pixel write with non-ok status");

  a_nowrite_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.write_valid |->
      out_item_o.pixel_addr == '0 && out_item_o.pixel_color == '0 && !out_item_o.last)
    else $error("non-write result carries pixel data");

  a_last_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last |-> out_item_o.write_valid)
    else $error("last flag without pixel write");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (.*);
